### rtl/wals_pkg.sv
package wals_pkg;

  // Default configuration
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;

  // Fixed port widths
  localparam int OUT_BITS = 16;
  localparam int COV_BITS = 8;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Classified command flags, carried through the queue
  typedef struct packed {
    logic op;
    logic dir_neg;
    logic major_y;
    logic thick;
  } wals_flags_t;

  localparam int FLAGS_BITS = $bits(wals_flags_t);

  // Back-end status, watched at the top level
  typedef struct packed {
    logic busy;       // slope divider running
    logic active;     // a line has steps left
    logic load;       // pixel beat loaded into the output register
    logic load_last;  // that beat is the final step
  } wals_status_t;

endpackage

### rtl/wals_front.sv
module wals_front #(
  parameter int COORD_BITS = wals_pkg::COORD_BITS
) (
  input  logic                     operation,
  input  logic [15:0]              start_x,
  input  logic [15:0]              start_y,
  input  logic [15:0]              end_x,
  input  logic [15:0]              end_y,
  input  logic                     thick,
  output wals_pkg::wals_flags_t    flags,
  output logic [COORD_BITS-1:0]    first_x,
  output logic [COORD_BITS-1:0]    first_y,
  output logic [COORD_BITS-1:0]    major,
  output logic [COORD_BITS-1:0]    minor
);

  logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
  logic signed [COORD_BITS:0]   diff_x, diff_y;
  logic        [COORD_BITS:0]   abs_x, abs_y;
  logic        [COORD_BITS-1:0] dx, dy;
  logic                         x_pos, x_neg, y_pos, y_neg;
  logic                         y_major, swap, dir_neg;

  // Only the low coordinate bits count, taken as signed
  assign sx = start_x[COORD_BITS-1:0];
  assign sy = start_y[COORD_BITS-1:0];
  assign ex = end_x[COORD_BITS-1:0];
  assign ey = end_y[COORD_BITS-1:0];

  // Deltas one bit wider so they never overflow
  assign diff_x = (COORD_BITS+1)'(ex) - (COORD_BITS+1)'(sx);
  assign diff_y = (COORD_BITS+1)'(ey) - (COORD_BITS+1)'(sy);

  assign x_neg = diff_x[COORD_BITS];
  assign y_neg = diff_y[COORD_BITS];
  assign x_pos = !x_neg && (diff_x != '0);
  assign y_pos = !y_neg && (diff_y != '0);

  assign abs_x = x_neg ? -diff_x : diff_x;
  assign abs_y = y_neg ? -diff_y : diff_y;
  assign dx    = abs_x[COORD_BITS-1:0];
  assign dy    = abs_y[COORD_BITS-1:0];

  // Axis choice, endpoint order and minor direction
  always_comb begin
    y_major = (dy >= dx);
    if (y_major) begin
      swap    = y_neg;
      dir_neg = swap ? x_pos : x_neg;
    end else begin
      swap    = x_pos;
      dir_neg = swap ? y_pos : y_neg;
    end
  end

  assign first_x = swap ? ex : sx;
  assign first_y = swap ? ey : sy;
  assign major   = y_major ? dy : dx;
  assign minor   = y_major ? dx : dy;

  assign flags.op      = operation;
  assign flags.dir_neg = dir_neg;
  assign flags.major_y = y_major;
  assign flags.thick   = thick;

endmodule

### rtl/wals_fifo.sv
module wals_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wals_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/wals_back.sv
module wals_back #(
  parameter int COORD_BITS = wals_pkg::COORD_BITS,
  parameter int FRAC_BITS  = wals_pkg::FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  wals_pkg::wals_flags_t  head_flags,
  input  logic [COORD_BITS-1:0]  head_x,
  input  logic [COORD_BITS-1:0]  head_y,
  input  logic [COORD_BITS-1:0]  head_major,
  input  logic [COORD_BITS-1:0]  head_minor,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            out_pixel_x,
  output logic [15:0]            out_pixel_y,
  output logic [15:0]            out_pair_x,
  output logic [15:0]            out_pair_y,
  output logic [7:0]             out_coverage,
  output logic                   out_minor_negative,
  output logic                   out_y_major,
  output logic                   out_thick_out,
  output logic                   out_last,
  output wals_pkg::wals_status_t status
);

  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  // Line state
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r, steps_r;
  logic [FRAC_BITS-1:0]  accum_r;
  logic [FRAC_BITS:0]    slope_r;
  logic                  dir_r, major_y_r, thick_r;
  logic                  active_r, busy_r;

  // Slope divider
  logic [COORD_BITS:0]   rem_r, rem_sub, rem_nxt;
  logic [FRAC_BITS:0]    quot_r, quot_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic                  rem_ge, div_done;

  // Output register
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] px_r, py_r, qx_r, qy_r;
  logic [7:0]            cov_r;
  logic                  dir_out_r, major_y_out_r, thick_out_r, last_r;

  // Step datapath
  logic [FRAC_BITS+1:0]  sum;
  logic [FRAC_BITS-1:0]  acc_nxt;
  logic                  carry;
  logic [COORD_BITS-1:0] step_x, step_y, pair_x, pair_y, steps_dec;
  logic                  step_last;

  logic                  can_load, is_step, do_step, do_start;

  function automatic logic [COORD_BITS-1:0] move_minor(input logic [COORD_BITS-1:0] c,
                                                      input logic neg);
    return neg ? c - COORD_BITS'(1) : c + COORD_BITS'(1);
  endfunction

  // Queue head dispatch
  assign can_load = !out_valid_r || out_ready;
  assign is_step  = (head_flags.op == wals_pkg::OP_STEP);
  assign pop      = head_valid && !busy_r && (!is_step || !active_r || can_load);
  assign do_step  = pop && is_step && active_r;
  assign do_start = pop && !is_step;

  // One restoring division step per cycle
  assign rem_ge   = (rem_r >= {1'b0, steps_r});
  assign rem_sub  = rem_ge ? rem_r - {1'b0, steps_r} : rem_r;
  assign rem_nxt  = {rem_sub[COORD_BITS-1:0], 1'b0};
  assign quot_nxt = {quot_r[FRAC_BITS-1:0], rem_ge};
  assign div_done = (cnt_r == CNT_W'(1));

  // Accumulator and pixel advance
  assign sum     = {2'b00, accum_r} + {1'b0, slope_r};
  assign carry   = |sum[FRAC_BITS+1:FRAC_BITS];
  assign acc_nxt = sum[FRAC_BITS-1:0];

  always_comb begin
    if (major_y_r) begin
      step_x = carry ? move_minor(cur_x_r, dir_r) : cur_x_r;
      step_y = cur_y_r + COORD_BITS'(1);
      pair_x = move_minor(step_x, dir_r);
      pair_y = step_y;
    end else begin
      step_y = carry ? move_minor(cur_y_r, dir_r) : cur_y_r;
      step_x = cur_x_r - COORD_BITS'(1);
      pair_x = step_x;
      pair_y = move_minor(step_y, dir_r);
    end
  end

  assign steps_dec = steps_r - COORD_BITS'(1);
  assign step_last = (steps_r == COORD_BITS'(1));

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_start) begin
        active_r <= 1'b0;
        busy_r   <= (head_major != '0);
      end else if (busy_r && div_done) begin
        active_r <= 1'b1;
        busy_r   <= 1'b0;
      end else if (do_step) begin
        active_r <= !step_last;
      end
      if (do_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Line datapath
  always_ff @(posedge clk) begin
    if (do_start) begin
      cur_x_r   <= head_x;
      cur_y_r   <= head_y;
      accum_r   <= '0;
      steps_r   <= head_major;
      dir_r     <= head_flags.dir_neg;
      major_y_r <= head_flags.major_y;
      thick_r   <= head_flags.thick;
      slope_r   <= '0;
      rem_r     <= {1'b0, head_minor};
      quot_r    <= '0;
      cnt_r     <= CNT_W'(FRAC_BITS + 1);
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
      cnt_r  <= cnt_r - CNT_W'(1);
      if (div_done) begin
        slope_r <= quot_nxt;
      end
    end else if (do_step) begin
      cur_x_r <= step_x;
      cur_y_r <= step_y;
      accum_r <= acc_nxt;
      steps_r <= steps_dec;
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (do_step) begin
      px_r          <= step_x;
      py_r          <= step_y;
      qx_r          <= pair_x;
      qy_r          <= pair_y;
      cov_r         <= acc_nxt[FRAC_BITS-1 -: 8];
      dir_out_r     <= dir_r;
      major_y_out_r <= major_y_r;
      thick_out_r   <= thick_r;
      last_r        <= step_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pixel_x        = 16'($signed(px_r));
  assign out_pixel_y        = 16'($signed(py_r));
  assign out_pair_x         = 16'($signed(qx_r));
  assign out_pair_y         = 16'($signed(qy_r));
  assign out_coverage       = cov_r;
  assign out_minor_negative = dir_out_r;
  assign out_y_major        = major_y_out_r;
  assign out_thick_out      = thick_out_r;
  assign out_last           = last_r;

  assign status.busy      = busy_r;
  assign status.active    = active_r;
  assign status.load      = do_step;
  assign status.load_last = do_step && step_last;

endmodule

### rtl/wu_antialiased_line_stepper.sv
// Antialiased line stepper. A start beat (operation 0) loads two endpoints and
// the width flag and gives no result; each step beat (operation 1) gives one
// pixel beat while a line is active and is dropped otherwise. Input beats are
// classified and queued (QUEUE_DEPTH entries), so the input keeps taking beats
// while the back end works or the output is stalled, until the queue fills. Step
// beats leave at one per cycle while the divider is idle and the output takes
// them. A start with a non-zero length occupies the back end while the bit-serial
// slope divider runs; steps queued behind it wait for the divider. A zero-length
// line yields no steps.
module wu_antialiased_line_stepper #(
  parameter int COORD_BITS  = wals_pkg::COORD_BITS,
  parameter int FRAC_BITS   = wals_pkg::FRAC_BITS,
  parameter int QUEUE_DEPTH = wals_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [15:0] in_start_x,
  input  logic [15:0] in_start_y,
  input  logic [15:0] in_end_x,
  input  logic [15:0] in_end_y,
  input  logic        in_thick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pixel_x,
  output logic [15:0] out_pixel_y,
  output logic [15:0] out_pair_x,
  output logic [15:0] out_pair_y,
  output logic [7:0]  out_coverage,
  output logic        out_minor_negative,
  output logic        out_y_major,
  output logic        out_thick_out,
  output logic        out_last
);

  localparam int FLAGS_W = wals_pkg::FLAGS_BITS;
  localparam int ENTRY_W = FLAGS_W + 4 * COORD_BITS;

  wals_pkg::wals_flags_t  front_flags, head_flags;
  wals_pkg::wals_status_t st;
  logic [COORD_BITS-1:0]  front_x, front_y, front_major, front_minor;
  logic [COORD_BITS-1:0]  head_x, head_y, head_major, head_minor;
  logic [ENTRY_W-1:0]     wdata, rdata;
  logic                   full, head_valid, pop;

  // Classify the incoming beat
  wals_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .operation(in_operation),
    .start_x  (in_start_x),
    .start_y  (in_start_y),
    .end_x    (in_end_x),
    .end_y    (in_end_y),
    .thick    (in_thick),
    .flags    (front_flags),
    .first_x  (front_x),
    .first_y  (front_y),
    .major    (front_major),
    .minor    (front_minor)
  );

  assign in_ready = !full;
  assign wdata    = {front_flags, front_x, front_y, front_major, front_minor};

  // Command queue between front and back
  wals_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .wdata    (wdata),
    .full     (full),
    .pop      (pop),
    .rdata    (rdata),
    .not_empty(head_valid)
  );

  assign head_flags = rdata[ENTRY_W-1 -: FLAGS_W];
  assign head_x     = rdata[4*COORD_BITS-1 -: COORD_BITS];
  assign head_y     = rdata[3*COORD_BITS-1 -: COORD_BITS];
  assign head_major = rdata[2*COORD_BITS-1 -: COORD_BITS];
  assign head_minor = rdata[COORD_BITS-1:0];

  // Divider and pixel stepper
  wals_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_flags        (head_flags),
    .head_x            (head_x),
    .head_y            (head_y),
    .head_major        (head_major),
    .head_minor        (head_minor),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_x       (out_pixel_x),
    .out_pixel_y       (out_pixel_y),
    .out_pair_x        (out_pair_x),
    .out_pair_y        (out_pair_y),
    .out_coverage      (out_coverage),
    .out_minor_negative(out_minor_negative),
    .out_y_major       (out_y_major),
    .out_thick_out     (out_thick_out),
    .out_last          (out_last),
    .status            (st)
  );

  // No pixel leaves while the slope is still being divided
  a_no_step_while_dividing : assert property (@(posedge clk) disable iff (!rst_n)
    st.busy |-> !st.load)
    else $error("pixel beat produced during slope division");

  // The final step closes the line
  a_last_ends_line : assert property (@(posedge clk) disable iff (!rst_n)
    st.load_last |=> !st.active)
    else $error("line still active after its last step");

  // Divider completion opens the line
  a_div_opens_line : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(st.busy) |-> st.active)
    else $error("division finished without an active line");

  // A loaded beat shows up on the output next cycle
  a_load_shows : assert property (@(posedge clk) disable iff (!rst_n)
    st.load |=> out_valid)
    else $error("loaded pixel beat not presented");

endmodule

### dv/wu_antialiased_line_stepper_tb.sv
module wu_antialiased_line_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One input beat as queued for the driver
  typedef struct {
    logic        op;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic        thick;
    int unsigned gap;
    bit          drain;
  } line_cmd_t;

  // One expected pixel beat
  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [15:0] pair_x;
    logic [15:0] pair_y;
    logic [7:0]  coverage;
    logic        minor_neg;
    logic        y_major;
    logic        thick;
    logic        last;
  } pixel_beat_t;

  // Walker state mirrored from the block
  typedef struct {
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [15:0] accum;
    logic [16:0] slope;
    logic [15:0] steps_left;
    logic        dir_neg;
    logic        major_y;
    logic        thick;
    logic        active;
  } walker_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = wals_pkg::OP_START;
  logic [15:0] in_start_x = '0;
  logic [15:0] in_start_y = '0;
  logic [15:0] in_end_x = '0;
  logic [15:0] in_end_y = '0;
  logic        in_thick = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pixel_x;
  logic [15:0] out_pixel_y;
  logic [15:0] out_pair_x;
  logic [15:0] out_pair_y;
  logic [7:0]  out_coverage;
  logic        out_minor_negative;
  logic        out_y_major;
  logic        out_thick_out;
  logic        out_last;

  line_cmd_t   pending_cmds[$];
  pixel_beat_t expected_pixels[$];
  walker_t     walk = '{default: '0};

  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned wait_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned results_seen = 0;
  int          errors = 0;

  wu_antialiased_line_stepper u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .in_thick           (in_thick),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_x        (out_pixel_x),
    .out_pixel_y        (out_pixel_y),
    .out_pair_x         (out_pair_x),
    .out_pair_y         (out_pair_y),
    .out_coverage       (out_coverage),
    .out_minor_negative (out_minor_negative),
    .out_y_major        (out_y_major),
    .out_thick_out      (out_thick_out),
    .out_last           (out_last)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Neighbour one pixel over on the minor axis
  function automatic logic [15:0] minor_step(input logic [15:0] c);
    return walk.dir_neg ? c - 16'd1 : c + 16'd1;
  endfunction

  // Start beat: order the endpoints, fix directions, divide for the slope
  task automatic load_line(input logic [15:0] c_sx, input logic [15:0] c_sy,
                           input logic [15:0] c_ex, input logic [15:0] c_ey,
                           input logic thk);
    int sx, sy, ex, ey, t, dx, dy, major, minor;
    sx = $signed(c_sx);
    sy = $signed(c_sy);
    ex = $signed(c_ex);
    ey = $signed(c_ey);
    dx = (ex >= sx) ? ex - sx : sx - ex;
    dy = (ey >= sy) ? ey - sy : sy - ey;
    walk.thick = thk;
    if (dy >= dx) begin
      // y-major walks with y rising
      if (sy > ey) begin
        t = sx; sx = ex; ex = t;
        t = sy; sy = ey; ey = t;
      end
      walk.dir_neg = (ex < sx);
      walk.major_y = 1'b1;
      major = dy;
      minor = dx;
    end else begin
      // x-major walks with x falling
      if (sx < ex) begin
        t = sx; sx = ex; ex = t;
        t = sy; sy = ey; ey = t;
      end
      walk.dir_neg = (ey < sy);
      walk.major_y = 1'b0;
      major = dx;
      minor = dy;
    end
    walk.cur_x = 16'(sx);
    walk.cur_y = 16'(sy);
    walk.accum = '0;
    walk.steps_left = 16'(major);
    if (major != 0) begin
      walk.slope = 17'((longint'(minor) << wals_pkg::FRAC_BITS) / longint'(major));
      walk.active = 1'b1;
    end else begin
      walk.slope = '0;
      walk.active = 1'b0;
    end
  endtask

  // Step beat: one pixel along the major axis, minor move on carry
  task automatic advance_pixel(output bit got, output pixel_beat_t px);
    logic [17:0] sum;
    logic        carry;
    got = 1'b0;
    px = '0;
    if (!walk.active || walk.steps_left == 16'd0) begin
      walk.active = 1'b0;
      return;
    end
    sum = {2'b00, walk.accum} + {1'b0, walk.slope};
    carry = (sum[17:16] != 2'b00);
    walk.accum = sum[15:0];
    if (walk.major_y) begin
      if (carry) walk.cur_x = minor_step(walk.cur_x);
      walk.cur_y = walk.cur_y + 16'd1;
      px.pair_x = minor_step(walk.cur_x);
      px.pair_y = walk.cur_y;
    end else begin
      if (carry) walk.cur_y = minor_step(walk.cur_y);
      walk.cur_x = walk.cur_x - 16'd1;
      px.pair_x = walk.cur_x;
      px.pair_y = minor_step(walk.cur_y);
    end
    walk.steps_left = walk.steps_left - 16'd1;
    if (walk.steps_left == 16'd0) walk.active = 1'b0;
    px.pixel_x = walk.cur_x;
    px.pixel_y = walk.cur_y;
    px.coverage = walk.accum[15:8];
    px.minor_neg = walk.dir_neg;
    px.y_major = walk.major_y;
    px.thick = walk.thick;
    px.last = (walk.steps_left == 16'd0);
    got = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Stimulus builders
  task automatic queue_cmd(input logic op, input int sx, input int sy,
                           input int ex, input int ey, input logic thk, input bit drain);
    line_cmd_t c;
    c.op = op;
    c.start_x = 16'(sx);
    c.start_y = 16'(sy);
    c.end_x = 16'(ex);
    c.end_y = 16'(ey);
    c.thick = thk;
    c.gap = tx_calm ? 0 : $urandom_range(0, 7);
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                            input logic thk, input int nsteps, input bit drain);
    queue_cmd(wals_pkg::OP_START, sx, sy, ex, ey, thk, drain);
    repeat (nsteps)
      queue_cmd(wals_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom,
                1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Short lines run to the end and a little past; long ones get cut off
  task automatic queue_random_line(input int sx, input int sy, input int ex, input int ey,
                                   input bit drain);
    int a, b, c, d, dx, dy, len, nsteps;
    a = $signed(16'(sx));
    b = $signed(16'(sy));
    c = $signed(16'(ex));
    d = $signed(16'(ey));
    dx = (c >= a) ? c - a : a - c;
    dy = (d >= b) ? d - b : b - d;
    len = (dx > dy) ? dx : dy;
    nsteps = (len <= 40) ? len + $urandom_range(0, 2) : $urandom_range(1, 12);
    queue_line(sx, sy, ex, ey, 1'($urandom_range(0, 1)), nsteps, drain);
  endtask

  // Driver: one beat at a time from the pending queue
  always @(negedge clk) begin : drive
    line_cmd_t cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else if (wait_cnt < pending_cmds[0].gap) begin
        wait_cnt++;
        in_valid <= 1'b0;
      end else if (pending_cmds[0].drain && expected_pixels.size() != 0) begin
        in_valid <= 1'b0;
      end else begin
        cmd = pending_cmds.pop_front();
        wait_cnt = 0;
        in_valid <= 1'b1;
        in_operation <= cmd.op;
        in_start_x <= cmd.start_x;
        in_start_y <= cmd.start_y;
        in_end_x <= cmd.end_x;
        in_end_y <= cmd.end_y;
        in_thick <= cmd.thick;
      end
    end
  end

  // Result side back-pressure, with calm stretches
  always @(negedge clk) begin : sink
    if (out_taken) begin
      results_seen++;
      if (results_seen % 32 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      stall_left = rx_calm ? 0 : $urandom_range(0, 7);
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: check pixel beats, then predict from accepted input beats
  always @(posedge clk) begin : watch
    pixel_beat_t want;
    bit          got;
    in_taken <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel beat, expected none actual x=%0h y=%0h",
                 $time, out_pixel_x, out_pixel_y);
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", want.pixel_x, out_pixel_x);
        check_field("pixel_y", want.pixel_y, out_pixel_y);
        check_field("pair_x", want.pair_x, out_pair_x);
        check_field("pair_y", want.pair_y, out_pair_y);
        check_field("coverage", 16'(want.coverage), 16'(out_coverage));
        check_field("minor_negative", 16'(want.minor_neg), 16'(out_minor_negative));
        check_field("y_major", 16'(want.y_major), 16'(out_y_major));
        check_field("thick_out", 16'(want.thick), 16'(out_thick_out));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      if (in_operation == wals_pkg::OP_START) begin
        load_line(in_start_x, in_start_y, in_end_x, in_end_y, in_thick);
      end else begin
        advance_pixel(got, want);
        if (got) expected_pixels.push_back(want);
      end
    end
  end

  // Stimulus and end of run
  initial begin : stim
    int kind, bx, by, n;
    // step with no line yet
    queue_cmd(wals_pkg::OP_STEP, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b0);
    // zero-length line at the coordinate extremes
    queue_line(-32768, 32767, -32768, 32767, 1'b1, 1, 1'b0);
    // diagonal, every step carries, then a step past the end
    queue_line(0, 0, 3, -3, 1'b0, 4, 1'b0);
    // flat line, zero slope, neighbour y wraps
    queue_line(-32768, 32767, -32765, 32767, 1'b1, 3, 1'b0);
    // vertical line, neighbour x wraps
    queue_line(32767, -2, 32767, 0, 1'b0, 2, 1'b0);
    // longest line, dropped by the next start
    queue_line(-32768, -32768, 32767, 32767, 1'b1, 3, 1'b0);
    // steep line, sent only once the pipe has drained
    queue_line(0, 0, -2, 5, 1'b0, 5, 1'b1);

    while (pending_cmds.size() < 840) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        bx = $urandom_range(0, 65535);
        by = $urandom_range(0, 65535);
        queue_random_line(bx, by, bx + $urandom_range(0, 24) - 12,
                          by + $urandom_range(0, 24) - 12, ($urandom_range(0, 7) == 0));
      end else if (kind == 7) begin
        bx = $urandom_range(0, 65535);
        by = $urandom_range(0, 65535);
        queue_line(bx, by, bx, by, 1'($urandom_range(0, 1)), $urandom_range(1, 2), 1'b0);
      end else if (kind == 8) begin
        queue_random_line($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n)
          queue_cmd(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom,
                    1'($urandom_range(0, 1)), 1'b0);
      end
    end

    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (64) @(posedge clk);
    if (errors == 0)
      $display("wu_antialiased_line_stepper_tb passed");
    else
      $display("wu_antialiased_line_stepper_tb failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("wu_antialiased_line_stepper_tb failed");
    $finish;
  end

endmodule
